// ===== rtl/core/cfa_pkg.sv =====
package cfa_pkg;

   // fixed-point format of a channel level
   localparam int FRAC_BITS = 16;
   localparam int LVL_W     = 8 + FRAC_BITS;
   localparam int TIME_W    = 16;
   localparam int MAG_W     = LVL_W + 2;

   // twice full scale, the cap on one tick's movement
   localparam logic [MAG_W-1:0] TWO_FULL = MAG_W'(255) << (FRAC_BITS + 1);

   localparam logic [7:0] BYTE_MAX = 8'd255;

   typedef enum logic [2:0] {
      MODE_TICK      = 3'd0,
      MODE_TRANSLATE = 3'd1,
      MODE_ASSIGN    = 3'd2,
      MODE_BLEND     = 3'd3,
      MODE_START     = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      CSR_FIRST  = 2'd0,
      CSR_SECOND = 2'd1,
      CSR_DUR    = 2'd2,
      CSR_DELAY  = 2'd3
   } csr_type;

   typedef enum logic [1:0] {
      STAGE_OUT    = 2'd0,
      STAGE_BACK   = 2'd1,
      STAGE_REPEAT = 2'd2
   } stage_type;

endpackage

// ===== rtl/core/rgba_color_fade_animator.sv =====
// Assign and a tick with no fade or animation go straight to the result. Translate runs
// the divider (32 steps) per channel; a fading tick runs the multiplier (16 steps) per
// moving channel, plus a translate when the animation moves on; blend runs both units
// per colour channel. One word at a time; next taken once the result is registered.
// Reset (synchronous, high) clears colour, fade and animation state and registers.
module rgba_color_fade_animator (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_target_red,
   input  logic [7:0]  req_target_green,
   input  logic [7:0]  req_target_blue,
   input  logic [7:0]  req_target_alpha,
   input  logic        req_use_alpha,
   input  logic [15:0] req_duration_ms,
   input  logic [15:0] req_elapsed_ms,
   input  logic [7:0]  req_blend_alpha,
   // response words
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_alpha_out,
   output logic        rsp_fading,
   output logic        rsp_animating,
   output logic [1:0]  rsp_anim_stage_out,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int LW = cfa_pkg::LVL_W;
   localparam int FB = cfa_pkg::FRAC_BITS;
   localparam int TW = cfa_pkg::TIME_W;
   localparam int MW = cfa_pkg::MAG_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FD_START,
      ST_FD_WAIT,
      ST_ANIM,
      ST_TR_CHECK,
      ST_TR_START,
      ST_TR_WAIT,
      ST_BL_START,
      ST_BL_MUL,
      ST_BL_DIV,
      ST_DONE
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [31:0]   first_ff, second_ff;
   logic [TW-1:0] adur_ff, delay_ff;

   // colour and fade state
   logic [LW-1:0] level_ff [4];
   logic [LW-1:0] smag_ff  [4];
   logic          sneg_ff  [4];
   logic [7:0]    goal_ff  [4];
   logic          fade_ff;
   logic [TW-1:0] flen_ff;
   logic          anim_ff;
   logic [1:0]    stage_ff;
   logic signed [TW+1:0] aclk_ff;

   // current word; tc/twa/tdur also take the animation's translate
   logic [2:0]    mode_ff;
   logic [7:0]    tc_ff [4];
   logic          twa_ff;
   logic [TW-1:0] tdur_ff;
   logic [TW-1:0] elap_ff;
   logic [7:0]    w_ff;
   logic [1:0]    ch_ff;
   logic [2:0]    match_ff;

   // output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_col_ff [4];
   logic       rsp_fade_ff, rsp_anim_ff;
   logic [1:0] rsp_stage_ff;

   // serial units
   logic              mul_start, mul_done;
   logic [LW-1:0]     mul_a;
   logic [TW-1:0]     mul_b;
   logic [LW+TW-1:0]  mul_p;
   logic              div_start, div_done;
   logic [31:0]       div_n;
   logic [TW-1:0]     div_d;
   logic [31:0]       div_q;

   cfa_mul #(.AW(LW), .BW(TW)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .product(mul_p)
   );

   cfa_div #(.NW(32), .DW(TW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_n),
      .divisor(div_d), .done(div_done), .quotient(div_q)
   );

   // translate checks over all four channels
   logic [LW-1:0] tgt_lvl [4];
   logic [3:0]    dzero;
   logic          all_zero, same_goal;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         tgt_lvl[i] = {tc_ff[i], {FB{1'b0}}};
         dzero[i]   = (level_ff[i] == tgt_lvl[i]);
      end
      if (!twa_ff) begin
         dzero[3] = 1'b1;
      end
      all_zero  = &dzero;
      same_goal = (goal_ff[0] == tc_ff[0]) && (goal_ff[1] == tc_ff[1]) &&
                  (goal_ff[2] == tc_ff[2]) && (!twa_ff || goal_ff[3] == tc_ff[3]);
   end

   // per-channel difference for the current channel
   logic [LW-1:0] cur_lvl, cur_tgt, dmag;
   logic          dneg, alpha_kept;

   assign cur_lvl    = level_ff[ch_ff];
   assign cur_tgt    = tgt_lvl[ch_ff];
   assign alpha_kept = (ch_ff == 2'd3) && !twa_ff;

   always_comb begin
      dneg = 1'b0;
      dmag = '0;
      if (!alpha_kept) begin
         dneg = cur_tgt < cur_lvl;
         dmag = dneg ? cur_lvl - cur_tgt : cur_tgt - cur_lvl;
      end
   end

   // fade movement for the current channel
   logic [MW-1:0] moved;
   logic [LW-1:0] goal_lvl;
   logic [MW:0]   nv_up, nv_dn;
   logic          hit;
   logic [LW-1:0] nv;

   always_comb begin
      moved    = (mul_p > (LW+TW)'(cfa_pkg::TWO_FULL)) ? cfa_pkg::TWO_FULL : mul_p[MW-1:0];
      goal_lvl = {goal_ff[ch_ff], {FB{1'b0}}};
      nv_up    = {3'b000, cur_lvl} + {1'b0, moved};
      nv_dn    = {3'b000, cur_lvl} - {1'b0, moved};
      if (sneg_ff[ch_ff]) begin
         hit = ({1'b0, moved} > {3'b000, cur_lvl}) || (nv_dn[LW-1:0] <= goal_lvl);
         nv  = nv_dn[LW-1:0];
      end else begin
         hit = nv_up >= {3'b000, goal_lvl};
         nv  = nv_up[LW-1:0];
      end
   end

   logic [2:0] match_in;
   assign match_in = match_ff + {2'b00, hit};

   // blend sum: level*(255-w) + (src*w) << FRAC
   logic [15:0] src_w;
   logic [31:0] blend_sum;
   assign src_w     = tc_ff[ch_ff] * w_ff;
   assign blend_sum = mul_p[31:0] + {src_w, {FB{1'b0}}};

   // quotient with the minimum step of one unit
   logic [LW-1:0] step_in;
   assign step_in = (div_q[LW-1:0] == '0 && dmag != '0) ? LW'(1) : div_q[LW-1:0];

   // unit hookups
   assign mul_start = (state_ff == ST_FD_START && smag_ff[ch_ff] != '0) ||
                      (state_ff == ST_BL_START);
   assign mul_a     = (state_ff == ST_BL_START) ? cur_lvl : smag_ff[ch_ff];
   assign mul_b     = (state_ff == ST_BL_START) ? {8'd0, cfa_pkg::BYTE_MAX - w_ff} : elap_ff;
   assign div_start = (state_ff == ST_TR_START) || (state_ff == ST_BL_MUL && mul_done);
   assign div_n     = (state_ff == ST_TR_START) ? {8'd0, dmag} : blend_sum;
   assign div_d     = (state_ff == ST_TR_START) ? tdur_ff : {8'd0, cfa_pkg::BYTE_MAX};

   logic signed [TW+1:0] aclk_in;
   assign aclk_in = aclk_ff - $signed({2'b00, elap_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= '0;
         second_ff    <= '0;
         adur_ff      <= '0;
         delay_ff     <= '0;
         for (int i = 0; i < 4; i++) begin
            level_ff[i] <= '0;
            smag_ff[i]  <= '0;
            sneg_ff[i]  <= 1'b0;
            goal_ff[i]  <= '0;
         end
         fade_ff      <= 1'b0;
         flen_ff      <= '0;
         anim_ff      <= 1'b0;
         stage_ff     <= cfa_pkg::STAGE_OUT;
         aclk_ff      <= '0;
         ch_ff        <= '0;
         match_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               cfa_pkg::CSR_FIRST:  first_ff  <= csr_wdata;
               cfa_pkg::CSR_SECOND: second_ff <= csr_wdata;
               cfa_pkg::CSR_DUR:    adur_ff   <= csr_wdata[TW-1:0];
               cfa_pkg::CSR_DELAY:  delay_ff  <= csr_wdata[TW-1:0];
               default: ;
            endcase
         end
         // ST_DONE reloads the output register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  mode_ff  <= req_mode;
                  tc_ff[0] <= req_target_red;
                  tc_ff[1] <= req_target_green;
                  tc_ff[2] <= req_target_blue;
                  tc_ff[3] <= req_target_alpha;
                  twa_ff   <= req_use_alpha;
                  tdur_ff  <= req_duration_ms;
                  elap_ff  <= req_elapsed_ms;
                  w_ff     <= req_blend_alpha;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               ch_ff    <= '0;
               match_ff <= '0;
               unique case (mode_ff)
                  cfa_pkg::MODE_TICK: begin
                     if (fade_ff) begin
                        state_ff <= ST_FD_START;
                     end else if (anim_ff) begin
                        state_ff <= ST_ANIM;
                     end else begin
                        state_ff <= ST_DONE;
                     end
                  end
                  cfa_pkg::MODE_TRANSLATE: state_ff <= ST_TR_CHECK;
                  cfa_pkg::MODE_ASSIGN: begin
                     for (int i = 0; i < 3; i++) begin
                        level_ff[i] <= tgt_lvl[i];
                     end
                     if (twa_ff) begin
                        level_ff[3] <= tgt_lvl[3];
                     end
                     fade_ff  <= 1'b0;
                     state_ff <= ST_DONE;
                  end
                  cfa_pkg::MODE_BLEND: state_ff <= ST_BL_START;
                  cfa_pkg::MODE_START: begin
                     level_ff[0] <= {first_ff[31:24], {FB{1'b0}}};
                     level_ff[1] <= {first_ff[23:16], {FB{1'b0}}};
                     level_ff[2] <= {first_ff[15:8], {FB{1'b0}}};
                     level_ff[3] <= {first_ff[7:0], {FB{1'b0}}};
                     fade_ff     <= 1'b0;
                     if (adur_ff != '0) begin
                        stage_ff <= cfa_pkg::STAGE_OUT;
                        aclk_ff  <= '0;
                        anim_ff  <= 1'b1;
                     end
                     state_ff <= ST_DONE;
                  end
                  default: state_ff <= ST_DONE;
               endcase
            end
            // fade advance, one channel at a time
            ST_FD_START: begin
               if (smag_ff[ch_ff] == '0) begin
                  match_ff <= match_ff + 3'd1;
                  if (ch_ff == 2'd3) begin
                     if (match_ff == 3'd3) begin
                        fade_ff <= 1'b0;
                     end
                     state_ff <= anim_ff ? ST_ANIM : ST_DONE;
                  end else begin
                     ch_ff <= ch_ff + 2'd1;
                  end
               end else begin
                  state_ff <= ST_FD_WAIT;
               end
            end
            ST_FD_WAIT: begin
               if (mul_done) begin
                  level_ff[ch_ff] <= hit ? goal_lvl : nv;
                  match_ff        <= match_in;
                  if (ch_ff == 2'd3) begin
                     if (match_in == 3'd4) begin
                        fade_ff <= 1'b0;
                     end
                     state_ff <= anim_ff ? ST_ANIM : ST_DONE;
                  end else begin
                     ch_ff    <= ch_ff + 2'd1;
                     state_ff <= ST_FD_START;
                  end
               end
            end
            // ping-pong step, only once no fade runs
            ST_ANIM: begin
               ch_ff <= '0;
               if (fade_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  unique case (stage_ff)
                     cfa_pkg::STAGE_OUT: begin
                        tc_ff[0] <= second_ff[31:24];
                        tc_ff[1] <= second_ff[23:16];
                        tc_ff[2] <= second_ff[15:8];
                        tc_ff[3] <= second_ff[7:0];
                        twa_ff   <= 1'b1;
                        tdur_ff  <= adur_ff >> 1;
                        stage_ff <= cfa_pkg::STAGE_BACK;
                        state_ff <= ST_TR_CHECK;
                     end
                     cfa_pkg::STAGE_BACK: begin
                        tc_ff[0] <= first_ff[31:24];
                        tc_ff[1] <= first_ff[23:16];
                        tc_ff[2] <= first_ff[15:8];
                        tc_ff[3] <= first_ff[7:0];
                        twa_ff   <= 1'b1;
                        tdur_ff  <= adur_ff >> 1;
                        stage_ff <= cfa_pkg::STAGE_REPEAT;
                        aclk_ff  <= $signed({2'b00, delay_ff});
                        state_ff <= ST_TR_CHECK;
                     end
                     cfa_pkg::STAGE_REPEAT: begin
                        aclk_ff <= aclk_in;
                        if (aclk_in <= 0) begin
                           stage_ff <= cfa_pkg::STAGE_OUT;
                        end
                        state_ff <= ST_DONE;
                     end
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            // translate: zero duration assigns, then the no-op checks
            ST_TR_CHECK: begin
               ch_ff <= '0;
               if (tdur_ff == '0) begin
                  for (int i = 0; i < 3; i++) begin
                     level_ff[i] <= tgt_lvl[i];
                  end
                  if (twa_ff) begin
                     level_ff[3] <= tgt_lvl[3];
                  end
                  fade_ff  <= 1'b0;
                  state_ff <= ST_DONE;
               end else if (all_zero) begin
                  fade_ff  <= 1'b0;
                  state_ff <= ST_DONE;
               end else if (fade_ff && same_goal && flen_ff == tdur_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  fade_ff  <= 1'b1;
                  flen_ff  <= tdur_ff;
                  state_ff <= ST_TR_START;
               end
            end
            ST_TR_START: state_ff <= ST_TR_WAIT;
            ST_TR_WAIT: begin
               if (div_done) begin
                  smag_ff[ch_ff] <= step_in;
                  sneg_ff[ch_ff] <= dneg;
                  goal_ff[ch_ff] <= alpha_kept ? cur_lvl[LW-1:FB] : tc_ff[ch_ff];
                  if (ch_ff == 2'd3) begin
                     state_ff <= ST_DONE;
                  end else begin
                     ch_ff    <= ch_ff + 2'd1;
                     state_ff <= ST_TR_START;
                  end
               end
            end
            // blend: multiply, then divide by 255, red to blue
            ST_BL_START: state_ff <= ST_BL_MUL;
            ST_BL_MUL: begin
               if (mul_done) begin
                  state_ff <= ST_BL_DIV;
               end
            end
            ST_BL_DIV: begin
               if (div_done) begin
                  level_ff[ch_ff] <= div_q[LW-1:0];
                  if (ch_ff == 2'd2) begin
                     fade_ff  <= 1'b0;
                     state_ff <= ST_DONE;
                  end else begin
                     ch_ff    <= ch_ff + 2'd1;
                     state_ff <= ST_BL_START;
                  end
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  for (int i = 0; i < 4; i++) begin
                     rsp_col_ff[i] <= level_ff[i][LW-1:FB];
                  end
                  rsp_fade_ff  <= fade_ff;
                  rsp_anim_ff  <= anim_ff;
                  rsp_stage_ff <= stage_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall          = reset || (state_ff != ST_IDLE);
   assign csr_ready          = !reset;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_red_out        = rsp_col_ff[0];
   assign rsp_green_out      = rsp_col_ff[1];
   assign rsp_blue_out       = rsp_col_ff[2];
   assign rsp_alpha_out      = rsp_col_ff[3];
   assign rsp_fading         = rsp_fade_ff;
   assign rsp_animating      = rsp_anim_ff;
   assign rsp_anim_stage_out = rsp_stage_ff;

endmodule

// ===== rtl/core/cfa_mul.sv =====
// shift-add multiplier, one multiplier bit per cycle
module cfa_mul #(
   parameter int AW = 24,
   parameter int BW = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic             done,
   output logic [AW+BW-1:0] product
);

   localparam int CW = $clog2(BW + 1);

   logic [AW-1:0]    a_ff;
   logic [AW+BW-1:0] acc_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [AW:0]      sum_in;

   assign sum_in  = {1'b0, acc_ff[AW+BW-1:BW]} + (acc_ff[0] ? {1'b0, a_ff} : '0);
   assign done    = done_ff;
   assign product = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            a_ff    <= a;
            acc_ff  <= {{AW{1'b0}}, b};
            cnt_ff  <= CW'(BW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            acc_ff <= {sum_in, acc_ff[BW-1:1]};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// ===== rtl/core/cfa_div.sv =====
// restoring divider, one quotient bit per cycle; divisor must be nonzero
module cfa_div #(
   parameter int NW = 32,
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] quo_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [DW+1:0] trial_in;

   assign trial_in = {1'b0, rem_ff, quo_ff[NW-1]} - {2'b00, dvs_ff};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
            cnt_ff  <= CW'(NW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (trial_in[DW+1]) begin
               rem_ff <= {rem_ff[DW-2:0], quo_ff[NW-1]};
            end else begin
               rem_ff <= trial_in[DW-1:0];
            end
            quo_ff <= {quo_ff[NW-2:0], ~trial_in[DW+1]};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// ===== tb/sv/rgba_color_fade_animator_tb.sv =====
`timescale 1ns / 1ps

module rgba_color_fade_animator_tb;

   // one request word as the predictor sees it
   typedef struct {
      cfa_pkg::mode_type mode;
      logic [7:0]  tgt [4];
      logic        use_alpha;
      logic [15:0] duration;
      logic [15:0] elapsed;
      logic [7:0]  weight;
   } fade_req_type;

   // one response word
   typedef struct {
      logic [7:0] level_byte [4];
      logic       fading;
      logic       animating;
      logic [1:0] stage;
   } fade_rsp_type;

   // colour state mirror plus the queue of responses still owed by the block
   class fade_scoreboard;
      longint     level [4];
      longint     step [4];
      logic [7:0] goal [4];
      bit         fade_on;
      int         fade_len;
      bit         anim_on;
      logic [1:0] stage;
      int         anim_clock;
      logic [31:0] colour_one, colour_two;
      int         anim_dur, repeat_delay;
      fade_rsp_type owed [$];
      int         errors;

      function new();
         for (int i = 0; i < 4; i++) begin
            level[i] = 0; step[i] = 0; goal[i] = 0;
         end
         fade_on = 0; fade_len = 0; anim_on = 0; stage = 0; anim_clock = 0;
         colour_one = 0; colour_two = 0; anim_dur = 0; repeat_delay = 0;
         errors = 0;
      endfunction

      function void write_reg(cfa_pkg::csr_type idx, logic [31:0] data);
         case (idx)
            cfa_pkg::CSR_FIRST:  colour_one   = data;
            cfa_pkg::CSR_SECOND: colour_two   = data;
            cfa_pkg::CSR_DUR:    anim_dur     = data[15:0];
            cfa_pkg::CSR_DELAY:  repeat_delay = data[15:0];
         endcase
      endfunction

      function void paint(logic [7:0] c [4], bit with_alpha);
         for (int i = 0; i < 3; i++) level[i] = longint'(c[i]) << cfa_pkg::FRAC_BITS;
         if (with_alpha) level[3] = longint'(c[3]) << cfa_pkg::FRAC_BITS;
         fade_on = 0;
      endfunction

      function void begin_fade(logic [7:0] c [4], bit with_alpha, int dur);
         longint diff [4];
         longint mag, q;
         bit     all_zero, same;
         if (dur == 0) begin
            paint(c, with_alpha);
            return;
         end
         all_zero = 1;
         for (int i = 0; i < 4; i++) begin
            diff[i] = (i == 3 && !with_alpha) ? 0 :
                      (longint'(c[i]) << cfa_pkg::FRAC_BITS) - level[i];
            if (diff[i] != 0) all_zero = 0;
         end
         if (all_zero) begin
            fade_on = 0;
            return;
         end
         same = 1;
         for (int i = 0; i < 3; i++) if (goal[i] != c[i]) same = 0;
         if (with_alpha && goal[3] != c[3]) same = 0;
         if (fade_on && same && fade_len == dur) return;
         fade_on  = 1;
         fade_len = dur;
         for (int i = 0; i < 4; i++) begin
            mag = diff[i] < 0 ? -diff[i] : diff[i];
            q   = mag / dur;
            if (mag != 0 && q == 0) q = 1;
            step[i] = diff[i] < 0 ? -q : q;
            goal[i] = (i == 3 && !with_alpha) ? level[3][cfa_pkg::FRAC_BITS +: 8] : c[i];
         end
      endfunction

      function void run_fade(int elapsed);
         longint full, g, mag, moved, nv;
         int     matched;
         full    = longint'(255) << cfa_pkg::FRAC_BITS;
         matched = 0;
         for (int i = 0; i < 4; i++) begin
            if (step[i] == 0) begin
               matched++;
               continue;
            end
            g   = longint'(goal[i]) << cfa_pkg::FRAC_BITS;
            mag = step[i] < 0 ? -step[i] : step[i];
            // movement saturates at twice full scale
            if (elapsed != 0 && elapsed > (2 * full) / mag) moved = 2 * full;
            else moved = mag * elapsed;
            if (step[i] < 0) begin
               nv = level[i] - moved;
               if (nv <= g) begin nv = g; matched++; end
            end else begin
               nv = level[i] + moved;
               if (nv >= g) begin nv = g; matched++; end
            end
            if (nv < 0) nv = 0;
            if (nv > full) nv = full;
            level[i] = nv;
         end
         if (matched >= 4) fade_on = 0;
      endfunction

      function void unpack(logic [31:0] p, output logic [7:0] c [4]);
         c[0] = p[31:24]; c[1] = p[23:16]; c[2] = p[15:8]; c[3] = p[7:0];
      endfunction

      function void run_anim(int elapsed);
         logic [7:0] c [4];
         if (fade_on) return;
         case (stage)
            cfa_pkg::STAGE_OUT: begin
               unpack(colour_two, c);
               begin_fade(c, 1, anim_dur / 2);
               stage = cfa_pkg::STAGE_BACK;
            end
            cfa_pkg::STAGE_BACK: begin
               unpack(colour_one, c);
               begin_fade(c, 1, anim_dur / 2);
               stage      = cfa_pkg::STAGE_REPEAT;
               anim_clock = repeat_delay;
            end
            cfa_pkg::STAGE_REPEAT: begin
               anim_clock -= elapsed;
               if (anim_clock <= 0) stage = cfa_pkg::STAGE_OUT;
            end
            default: ;
         endcase
      endfunction

      function void note_request(fade_req_type r);
         fade_rsp_type e;
         logic [7:0]   c [4];
         longint       mix;
         case (r.mode)
            cfa_pkg::MODE_TICK: begin
               if (fade_on) run_fade(r.elapsed);
               if (anim_on) run_anim(r.elapsed);
            end
            cfa_pkg::MODE_TRANSLATE: begin_fade(r.tgt, r.use_alpha, r.duration);
            cfa_pkg::MODE_ASSIGN:    paint(r.tgt, r.use_alpha);
            cfa_pkg::MODE_BLEND: begin
               for (int i = 0; i < 3; i++) begin
                  mix = level[i] * (255 - r.weight) +
                        (longint'(r.tgt[i]) << cfa_pkg::FRAC_BITS) * r.weight;
                  level[i] = mix / 255;
               end
               fade_on = 0;
            end
            cfa_pkg::MODE_START: begin
               unpack(colour_one, c);
               paint(c, 1);
               if (anim_dur != 0) begin
                  stage = cfa_pkg::STAGE_OUT; anim_clock = 0; anim_on = 1;
               end
            end
            default: ;
         endcase
         for (int i = 0; i < 4; i++) e.level_byte[i] = level[i][cfa_pkg::FRAC_BITS +: 8];
         e.fading = fade_on; e.animating = anim_on; e.stage = stage;
         owed.push_back(e);
      endfunction

      function void check_response(fade_rsp_type a);
         fade_rsp_type e;
         string        names [4] = '{"red", "green", "blue", "alpha"};
         if (owed.size() == 0) begin
            $display("%0t: unexpected response word", $time);
            errors++;
            return;
         end
         e = owed.pop_front();
         for (int i = 0; i < 4; i++)
            if (a.level_byte[i] !== e.level_byte[i]) begin
               $display("%0t: %s exp %0d got %0d", $time, names[i], e.level_byte[i],
                        a.level_byte[i]);
               errors++;
            end
         if (a.fading !== e.fading) begin
            $display("%0t: fading exp %0b got %0b", $time, e.fading, a.fading);
            errors++;
         end
         if (a.animating !== e.animating) begin
            $display("%0t: animating exp %0b got %0b", $time, e.animating, a.animating);
            errors++;
         end
         if (a.stage !== e.stage) begin
            $display("%0t: stage exp %0d got %0d", $time, e.stage, a.stage);
            errors++;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [2:0]  req_mode;
   logic [7:0]  req_target_red, req_target_green, req_target_blue, req_target_alpha;
   logic        req_use_alpha;
   logic [15:0] req_duration_ms, req_elapsed_ms;
   logic [7:0]  req_blend_alpha;
   logic        rsp_valid, rsp_stall;
   logic [7:0]  rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out;
   logic        rsp_fading, rsp_animating;
   logic [1:0]  rsp_anim_stage_out;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   fade_scoreboard colour_sb;
   bit             rsp_hold_on;   // receiver takes every word at once while set

   rgba_color_fade_animator dut (.*);

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // safety net: far above the slowest legal run
   initial begin
      #50ms;
      $display("rgba_color_fade_animator_tb NOT OK");
      $finish;
   end

   // response side: random stall per word, check at the rising edge
   initial begin
      fade_rsp_type got;
      int           gap;
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         gap = rsp_hold_on ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got.level_byte[0] = rsp_red_out;
         got.level_byte[1] = rsp_green_out;
         got.level_byte[2] = rsp_blue_out;
         got.level_byte[3] = rsp_alpha_out;
         got.fading        = rsp_fading;
         got.animating     = rsp_animating;
         got.stage         = rsp_anim_stage_out;
         colour_sb.check_response(got);
         @(negedge clock);
      end
   end

   task automatic write_reg(cfa_pkg::csr_type idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      colour_sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // drain: stop sending, every owed word back, then let any late work settle
   task automatic drain();
      req_valid <= 1'b0;
      while (colour_sb.owed.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic send_word(fade_req_type r);
      int gap;
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= r.mode;
      req_target_red   <= r.tgt[0];
      req_target_green <= r.tgt[1];
      req_target_blue  <= r.tgt[2];
      req_target_alpha <= r.tgt[3];
      req_use_alpha    <= r.use_alpha;
      req_duration_ms  <= r.duration;
      req_elapsed_ms   <= r.elapsed;
      req_blend_alpha  <= r.weight;
      do @(posedge clock); while (req_stall);
      colour_sb.note_request(r);
      @(negedge clock);
   endtask

   function automatic fade_req_type make_word(logic [2:0] mode, logic [31:0] rgba,
                                               bit ua, int dur, int el, int w);
      fade_req_type r;
      r.mode = cfa_pkg::mode_type'(mode);
      r.tgt[0] = rgba[31:24]; r.tgt[1] = rgba[23:16];
      r.tgt[2] = rgba[15:8];  r.tgt[3] = rgba[7:0];
      r.use_alpha = ua; r.duration = 16'(dur); r.elapsed = 16'(el); r.weight = 8'(w);
      return r;
   endfunction

   // random word biased toward short fades and small ticks so the animation turns over
   function automatic fade_req_type rand_word();
      int pick;
      int dur, el;
      bit ua;
      pick = $urandom_range(0, 99);
      dur  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
      el   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
      ua   = 1'($urandom_range(0, 1));
      if (pick < 50)      return make_word(cfa_pkg::MODE_TICK, $urandom, ua, dur, el, 0);
      else if (pick < 72) return make_word(cfa_pkg::MODE_TRANSLATE, $urandom, ua, dur,
                                           el, $urandom_range(0, 255));
      else if (pick < 82) return make_word(cfa_pkg::MODE_ASSIGN, $urandom, ua, dur, el,
                                           $urandom_range(0, 255));
      else if (pick < 92) return make_word(cfa_pkg::MODE_BLEND, $urandom, ua, dur, el,
                                           $urandom_range(0, 255));
      else if (pick < 97) return make_word(cfa_pkg::MODE_START, $urandom, ua, dur, el, 0);
      // unused modes
      return make_word(3'($urandom_range(5, 7)), $urandom, ua, dur, el,
                       $urandom_range(0, 255));
   endfunction

   initial begin
      colour_sb   = new();
      rsp_hold_on = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_mode    = cfa_pkg::MODE_TICK;
      {req_target_red, req_target_green, req_target_blue, req_target_alpha} = '0;
      req_use_alpha = 1'b0;
      req_duration_ms = '0; req_elapsed_ms = '0; req_blend_alpha = '0;
      csr_valid = 1'b0; csr_index = cfa_pkg::CSR_FIRST; csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: start with animation period zero, so the start does not latch
      send_word(make_word(cfa_pkg::MODE_START, 0, 0, 0, 0, 0));
      send_word(make_word(cfa_pkg::MODE_TICK, 0, 0, 0, 0, 0));
      send_word(make_word(cfa_pkg::MODE_ASSIGN, 32'hFFFF_FFFF, 1, 0, 0, 0));
      send_word(make_word(cfa_pkg::MODE_TRANSLATE, 32'h0000_0000, 0, 65535, 0, 0)); // longest duration
      send_word(make_word(cfa_pkg::MODE_TRANSLATE, 32'h0000_0000, 0, 65535, 0, 0)); // repeat
      send_word(make_word(cfa_pkg::MODE_TICK, 0, 0, 0, 65535, 0));            // longest tick, still short of the goal
      send_word(make_word(cfa_pkg::MODE_TRANSLATE, 32'h10F0_8040, 1, 3, 0, 0));
      send_word(make_word(cfa_pkg::MODE_TICK, 0, 0, 0, 1, 0));
      send_word(make_word(cfa_pkg::MODE_TICK, 0, 0, 0, 2, 0));
      send_word(make_word(cfa_pkg::MODE_TRANSLATE, 32'h10F0_8000, 0, 7, 0, 0));  // same colour, new duration
      send_word(make_word(cfa_pkg::MODE_TRANSLATE, 32'hFFFF_FFFF, 1, 0, 0, 0));  // zero duration
      send_word(make_word(cfa_pkg::MODE_BLEND, 32'h0000_0000, 0, 0, 0, 255));
      send_word(make_word(cfa_pkg::MODE_BLEND, 32'hFFFF_FFFF, 0, 0, 0, 0));
      send_word(make_word(cfa_pkg::MODE_BLEND, 32'hFF00_FF00, 1, 0, 0, 128));
      send_word(make_word(7, 32'h1234_5678, 1, 5, 5, 5));
      send_word(make_word(5, 0, 0, 0, 0, 0));

      // pause for the pipe to empty before touching registers
      rsp_hold_on = 1;
      drain();
      rsp_hold_on = 0;
      write_reg(cfa_pkg::CSR_FIRST, 32'h0000_0000);
      write_reg(cfa_pkg::CSR_SECOND, 32'hFFFF_FFFF);
      write_reg(cfa_pkg::CSR_DUR, 16'd1);       // half period zero: colours assigned outright
      write_reg(cfa_pkg::CSR_DELAY, 16'd0);
      send_word(make_word(cfa_pkg::MODE_START, 0, 0, 0, 0, 0));
      repeat (6) send_word(make_word(cfa_pkg::MODE_TICK, 0, 0, 0, 0, 0));

      // several register settings, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: begin
               write_reg(cfa_pkg::CSR_FIRST, $urandom); write_reg(cfa_pkg::CSR_SECOND, $urandom);
               write_reg(cfa_pkg::CSR_DUR, 16'd8); write_reg(cfa_pkg::CSR_DELAY, 16'd3);
            end
            1: begin
               write_reg(cfa_pkg::CSR_DUR, 16'hFFFF); write_reg(cfa_pkg::CSR_DELAY, 16'hFFFF);
            end
            2: begin
               write_reg(cfa_pkg::CSR_FIRST, 32'hFFFF_FFFF);
               write_reg(cfa_pkg::CSR_SECOND, 32'h0);
               write_reg(cfa_pkg::CSR_DUR, 16'd0);
            end
            default: begin
               write_reg(cfa_pkg::CSR_FIRST, $urandom); write_reg(cfa_pkg::CSR_SECOND, $urandom);
               write_reg(cfa_pkg::CSR_DUR, $urandom_range(2, 30));
               write_reg(cfa_pkg::CSR_DELAY, $urandom_range(0, 10));
            end
         endcase
         send_word(make_word(cfa_pkg::MODE_START, 0, 0, 0, 0, 0));
         for (int k = 0; k < 90; k++) send_word(rand_word());
      end

      drain();
      if (colour_sb.errors == 0 && colour_sb.owed.size() == 0)
         $display("rgba_color_fade_animator_tb OK");
      else
         $display("rgba_color_fade_animator_tb NOT OK");
      $finish;
   end

endmodule
